// ===== sv/ldin_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldin_pkg
// Shared types, codes and defaults of the log-domain interpolating normalizer.
// ----------------------------------------------------------------------------
package ldin_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int LOG_FRAC_DEF = 16;
	localparam int VAL_W        = 32;
	localparam int FAC_W        = 24;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	typedef struct packed {
		logic [1:0]       command;
		logic [VAL_W-1:0] sample_value;
		logic [FAC_W-1:0] point_factor;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0] normalized_value;
		logic [1:0]       status;
	} out_word_t;

	// flags of the lookup record that ripples down the cell chain
	typedef struct packed {
		logic found;
		logic direct;
	} rec_flags_t;

endpackage

// ===== sv/ldin_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldin_cell
// One table slot: holds a point, takes part in sorted insert, and refines the
// lookup record handed on by its left neighbor.
// ----------------------------------------------------------------------------
module ldin_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int LW  = 21
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [CW-1:0]             count,
	input  logic                      insert,
	input  logic [ldin_pkg::VAL_W-1:0] val,
	input  logic [ldin_pkg::FAC_W-1:0] fac,
	input  logic [LW-1:0]             new_l,
	input  logic [LW-1:0]             lr,
	input  logic                      left_gt,
	input  logic [ldin_pkg::VAL_W-1:0] left_v,
	input  logic [ldin_pkg::FAC_W-1:0] left_n,
	input  logic [LW-1:0]             left_l,
	output logic                      gt,
	output logic [ldin_pkg::VAL_W-1:0] v,
	output logic [ldin_pkg::FAC_W-1:0] n,
	output logic [LW-1:0]             l,
	input  ldin_pkg::rec_flags_t      rin_f,
	input  logic [ldin_pkg::FAC_W-1:0] rin_na,
	input  logic [ldin_pkg::FAC_W-1:0] rin_nb,
	input  logic [LW-1:0]             rin_la,
	input  logic [LW-1:0]             rin_lb,
	output ldin_pkg::rec_flags_t      rout_f,
	output logic [ldin_pkg::FAC_W-1:0] rout_na,
	output logic [ldin_pkg::FAC_W-1:0] rout_nb,
	output logic [LW-1:0]             rout_la,
	output logic [LW-1:0]             rout_lb
);
	import ldin_pkg::*;

	logic [VAL_W-1:0] v_q;
	logic [FAC_W-1:0] n_q;
	logic [LW-1:0]    l_q;
	logic             occ, last, wr;

	rec_flags_t       f_d, f_q;
	logic [FAC_W-1:0] na_d, nb_d, na_q, nb_q;
	logic [LW-1:0]    la_d, lb_d, la_q, lb_q;

	assign occ  = CW'(IDX) < count;
	assign last = count == CW'(IDX + 1);
	assign gt   = occ && (v_q > val);
	assign wr   = insert && (gt || count == CW'(IDX));

	assign v = v_q;
	assign n = n_q;
	assign l = l_q;

	// shift right from the neighbor while its value is larger, else take new
	always_ff @(posedge clk) begin
		if (wr) begin
			if (left_gt) begin
				v_q <= left_v;
				n_q <= left_n;
				l_q <= left_l;
			end else begin
				v_q <= val;
				n_q <= fac;
				l_q <= new_l;
			end
		end
	end

	always_comb begin
		f_d  = rin_f;
		na_d = rin_na;
		nb_d = rin_nb;
		la_d = rin_la;
		lb_d = rin_lb;
		if (IDX == 0 && val < v_q) begin
			f_d  = '{found: 1'b1, direct: 1'b1};
			na_d = n_q;
		end else if (IDX != 0 && occ && !rin_f.found && l_q >= lr) begin
			// first upper point at or above the query position
			na_d = left_n;
			la_d = left_l;
			nb_d = n_q;
			lb_d = l_q;
			f_d  = '{found: 1'b1, direct: !(l_q > left_l)};
		end
		if (last && val >= v_q) begin
			f_d  = '{found: 1'b1, direct: 1'b1};
			na_d = n_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q <= '0;
		end else begin
			f_q <= f_d;
		end
	end

	always_ff @(posedge clk) begin
		na_q <= na_d;
		nb_q <= nb_d;
		la_q <= la_d;
		lb_q <= lb_d;
	end

	assign rout_f  = f_q;
	assign rout_na = na_q;
	assign rout_nb = nb_q;
	assign rout_la = la_q;
	assign rout_lb = lb_q;

endmodule

// ===== sv/ldin_log2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldin_log2
// Iterative log2(v/256 + 1): normalize one bit a cycle, then one squaring of
// the mantissa per fraction bit.
// ----------------------------------------------------------------------------
module ldin_log2 #(
	parameter int LOG_FRAC = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ldin_pkg::VAL_W-1:0] v,
	output logic                       done,
	output logic [LOG_FRAC+4:0]        lpos
);
	import ldin_pkg::*;

	localparam int KW = $clog2(LOG_FRAC);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQR  = 3'b100
	} lstate_t;

	lstate_t             state_q;
	logic [32:0]         x_q;
	logic [5:0]          p_q;
	logic [31:0]         m_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [KW-1:0]       k_q;
	logic                done_q;
	logic [63:0]         prod;
	logic [32:0]         t;
	logic [4:0]          ip;

	assign prod = 64'(m_q) * 64'(m_q);
	assign t    = prod[63:31];
	assign ip   = 5'(p_q - 6'd8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) state_q <= L_NORM;
				end
				L_NORM: begin
					if (x_q[32]) state_q <= L_SQR;
				end
				L_SQR: begin
					if (k_q == KW'(LOG_FRAC - 1)) begin
						state_q <= L_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				x_q <= {1'b0, v} + 33'd256;
				p_q <= 6'd32;
				k_q <= '0;
			end
			L_NORM: begin
				if (x_q[32]) begin
					m_q <= x_q[32:1];
				end else begin
					x_q <= {x_q[31:0], 1'b0};
					p_q <= p_q - 6'd1;
				end
			end
			L_SQR: begin
				k_q <= k_q + 1'b1;
				frac_q <= {frac_q[LOG_FRAC-2:0], t[32]};
				m_q <= t[32] ? t[32:1] : t[31:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign lpos = {ip, frac_q};

endmodule

// ===== sv/ldin_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldin_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ldin_div #(
	parameter int NW = 48,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CNW = $clog2(NW + 1);

	logic [NW-1:0]  q_q;
	logic [DW-1:0]  r_q, d_q;
	logic [CNW-1:0] cnt_q;
	logic           run_q, done_q;
	logic [DW:0]    trial, diff;
	logic           ge;

	assign trial = {r_q, q_q[NW-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CNW'(NW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			d_q   <= den;
			r_q   <= '0;
			cnt_q <= '0;
		end else if (run_q) begin
			q_q   <= {q_q[NW-2:0], ge};
			r_q   <= ge ? diff[DW-1:0] : trial[DW-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ===== sv/log_domain_interpolating_normalizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_domain_interpolating_normalizer_unit
// Sorted point table in a cell chain, log-domain interpolation, division.
// ----------------------------------------------------------------------------
// One word is taken when start is high and busy is low; its result shows on
// res for exactly one cycle with done high and cannot be held off. Clear,
// unused commands, an add to a full table and a query on an empty table
// answer in the cycle after acceptance. An add waits for the log unit, and
// the insert through the chain happens as the log result arrives. A query
// waits for the log unit, then for the lookup record to ripple down the cell
// chain, then for passes of the bit-serial divider: one pass for a factor
// taken straight from a point, a multiply step and two passes for an
// interpolated factor. A zero factor skips the final pass: a direct one ends
// after the lookup, an interpolated one after the first pass.
// ----------------------------------------------------------------------------
module log_domain_interpolating_normalizer_unit #(
	parameter int DEPTH    = ldin_pkg::DEPTH_DEF,
	parameter int LOG_FRAC = ldin_pkg::LOG_FRAC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ldin_pkg::in_word_t  cmd,
	output logic                done,
	output ldin_pkg::out_word_t res
);
	import ldin_pkg::*;

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LW  = LOG_FRAC + 5;
	localparam int PW  = FAC_W + LW;
	localparam int NW  = (PW + 1 > 48) ? PW + 1 : 48;
	localparam int DW  = (LW > FAC_W) ? LW : FAC_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOG  = 6'b000010,
		S_SCAN = 6'b000100,
		S_MUL  = 6'b001000,
		S_IDIV = 6'b010000,
		S_FDIV = 6'b100000
	} state_t;

	state_t           state_q;
	logic [1:0]       cmd_q;
	logic [VAL_W-1:0] val_q;
	logic [FAC_W-1:0] fac_q;
	logic [LW-1:0]    lr_q;
	logic [CW-1:0]    count_q, scan_q;
	logic [PW-1:0]    p0_q, p1_q;
	logic             done_q;
	out_word_t        res_q;

	logic             log_start, log_done, insert;
	logic [LW-1:0]    lpos;
	logic             div_start, div_done;
	logic [NW-1:0]    div_num, div_quot;
	logic [DW-1:0]    div_den;
	logic [FAC_W-1:0] fsel;
	logic             sat;

	logic             c_gt [DEPTH];
	logic [VAL_W-1:0] c_v  [DEPTH];
	logic [FAC_W-1:0] c_n  [DEPTH];
	logic [LW-1:0]    c_l  [DEPTH];
	logic             l_gt [DEPTH];
	logic [VAL_W-1:0] l_v  [DEPTH];
	logic [FAC_W-1:0] l_n  [DEPTH];
	logic [LW-1:0]    l_l  [DEPTH];
	rec_flags_t       ri_f [DEPTH];
	logic [FAC_W-1:0] ri_na[DEPTH], ri_nb[DEPTH];
	logic [LW-1:0]    ri_la[DEPTH], ri_lb[DEPTH];
	rec_flags_t       ro_f [DEPTH];
	logic [FAC_W-1:0] ro_na[DEPTH], ro_nb[DEPTH];
	logic [LW-1:0]    ro_la[DEPTH], ro_lb[DEPTH];

	assign busy   = state_q != S_IDLE;
	assign insert = state_q == S_LOG && log_done && cmd_q == CMD_ADD;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign l_gt[i]  = 1'b0;
			assign l_v[i]   = '0;
			assign l_n[i]   = '0;
			assign l_l[i]   = '0;
			assign ri_f[i]  = '0;
			assign ri_na[i] = '0;
			assign ri_nb[i] = '0;
			assign ri_la[i] = '0;
			assign ri_lb[i] = '0;
		end else begin : g_link
			assign l_gt[i]  = c_gt[i-1];
			assign l_v[i]   = c_v[i-1];
			assign l_n[i]   = c_n[i-1];
			assign l_l[i]   = c_l[i-1];
			assign ri_f[i]  = ro_f[i-1];
			assign ri_na[i] = ro_na[i-1];
			assign ri_nb[i] = ro_nb[i-1];
			assign ri_la[i] = ro_la[i-1];
			assign ri_lb[i] = ro_lb[i-1];
		end
		ldin_cell #(.IDX(i), .CW(CW), .LW(LW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.count  (count_q),
			.insert (insert),
			.val    (val_q),
			.fac    (fac_q),
			.new_l  (lpos),
			.lr     (lr_q),
			.left_gt(l_gt[i]),
			.left_v (l_v[i]),
			.left_n (l_n[i]),
			.left_l (l_l[i]),
			.gt     (c_gt[i]),
			.v      (c_v[i]),
			.n      (c_n[i]),
			.l      (c_l[i]),
			.rin_f  (ri_f[i]),
			.rin_na (ri_na[i]),
			.rin_nb (ri_nb[i]),
			.rin_la (ri_la[i]),
			.rin_lb (ri_lb[i]),
			.rout_f (ro_f[i]),
			.rout_na(ro_na[i]),
			.rout_nb(ro_nb[i]),
			.rout_la(ro_la[i]),
			.rout_lb(ro_lb[i])
		);
	end

	ldin_log2 #(.LOG_FRAC(LOG_FRAC)) u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.start (log_start),
		.v     (cmd.sample_value),
		.done  (log_done),
		.lpos  (lpos)
	);

	// one divider serves the interpolation and the final quotient
	ldin_div #(.NW(NW), .DW(DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign fsel = (state_q == S_IDIV) ? div_quot[FAC_W-1:0] : ro_na[DEPTH-1];
	assign sat  = div_quot[NW-1:VAL_W] != '0;

	always_comb begin
		log_start = 1'b0;
		div_start = 1'b0;
		div_num   = NW'({val_q, 16'b0});
		div_den   = DW'(fsel);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					log_start = (cmd.command == CMD_ADD && count_q < CW'(DEPTH)) ||
						(cmd.command == CMD_QUERY && count_q != '0);
				end
			end
			S_SCAN: begin
				div_start = scan_q == CW'(DEPTH) && ro_f[DEPTH-1].direct && fsel != '0;
			end
			S_MUL: begin
				div_start = 1'b1;
				div_num   = NW'(p0_q) + NW'(p1_q);
				div_den   = DW'(ro_lb[DEPTH-1] - ro_la[DEPTH-1]);
			end
			S_IDIV: begin
				div_start = div_done && fsel != '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd.command)
							CMD_ADD: begin
								if (count_q < CW'(DEPTH)) state_q <= S_LOG;
								else done_q <= 1'b1;
							end
							CMD_QUERY: begin
								if (count_q != '0) state_q <= S_LOG;
								else done_q <= 1'b1;
							end
							CMD_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_LOG: begin
					if (log_done) begin
						if (cmd_q == CMD_ADD) begin
							count_q <= count_q + 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_q == CW'(DEPTH)) begin
						if (!ro_f[DEPTH-1].direct) begin
							state_q <= S_MUL;
						end else if (fsel == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FDIV;
						end
					end
				end
				S_MUL: state_q <= S_IDIV;
				S_IDIV: begin
					if (div_done) begin
						if (fsel == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FDIV;
						end
					end
				end
				S_FDIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= cmd.command;
					val_q <= cmd.sample_value;
					fac_q <= cmd.point_factor;
					res_q.normalized_value <= '0;
					res_q.status <= ST_OK;
					if (cmd.command == CMD_ADD && count_q >= CW'(DEPTH))
						res_q.status <= ST_FULL;
					if (cmd.command == CMD_QUERY && count_q == '0)
						res_q.status <= ST_EMPTY;
				end
			end
			S_LOG: begin
				lr_q   <= lpos;
				scan_q <= '0;
			end
			S_SCAN: begin
				scan_q <= scan_q + 1'b1;
				p0_q <= PW'(ro_na[DEPTH-1]) * PW'(ro_lb[DEPTH-1] - lr_q);
				p1_q <= PW'(ro_nb[DEPTH-1]) * PW'(lr_q - ro_la[DEPTH-1]);
				if (scan_q == CW'(DEPTH) && ro_f[DEPTH-1].direct && fsel == '0)
					res_q.status <= ST_ZERO;
			end
			S_IDIV: begin
				if (div_done && fsel == '0) res_q.status <= ST_ZERO;
			end
			S_FDIV: begin
				res_q.normalized_value <= sat ? '1 : div_quot[VAL_W-1:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

	a_status_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.status == ST_OK || res.normalized_value == '0))
		else $error("nonzero status with nonzero value");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("point count beyond depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.command == CMD_CLEAR |=> done && count_q == '0)
		else $error("clear did not empty the table");

	a_log_in_log: assert property (@(posedge clk) disable iff (!arst_n)
		log_done |-> state_q == S_LOG)
		else $error("log result outside log wait");

endmodule

// ===== tb/log_domain_interpolating_normalizer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_domain_interpolating_normalizer_unit_test
// Self-checking bench for the sorted-table log-domain normalizer.
// ----------------------------------------------------------------------------
// Words are sent in random bursts. Each accepted word is run through a local
// model of the point table and the log interpolation, and the expected word
// is queued. Every done pulse is compared field by field with the queue head.
// Directed tests cover the table edges and the special cases; a random phase
// builds small tables and queries them, mostly between points.
// ----------------------------------------------------------------------------
module log_domain_interpolating_normalizer_unit_test;
	import ldin_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         NPTS       = DEPTH_DEF;
	localparam int         LFB        = LOG_FRAC_DEF;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	logic      done;
	in_word_t  cmd = '0;
	out_word_t res;

	log_domain_interpolating_normalizer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the point table
	logic [31:0] tbl_val [NPTS];
	logic [23:0] tbl_fac [NPTS];
	int          tbl_cnt;

	out_word_t   pending_words [$];
	int          mismatches;
	int          words_sent;
	int          burst_left;
	int          status_seen [4];

	function automatic logic [63:0] log_position(input logic [31:0] v);
		logic [63:0] x, t, m, frac;
		int          p;
		x = 64'(v) + 64'd256;
		t = x;
		p = 0;
		frac = '0;
		while (t > 1) begin
			t = t >> 1;
			p++;
		end
		if (p >= 31) m = x >> (p - 31);
		else m = x << (31 - p);
		for (int k = 0; k < LFB; k++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(p - 8) << LFB) | frac;
	endfunction

	function automatic logic [23:0] interpolated_factor(input logic [31:0] r);
		logic [63:0] lr, l0, l1, num;
		int          i;
		lr = log_position(r);
		i = 0;
		for (int j = 0; j + 1 < tbl_cnt; j++) begin
			if (log_position(tbl_val[j]) <= lr && lr <= log_position(tbl_val[j+1])) begin
				i = j;
				break;
			end
		end
		l0 = log_position(tbl_val[i]);
		l1 = log_position(tbl_val[i+1]);
		if (l1 <= l0 || lr < l0 || lr > l1) return tbl_fac[i];
		num = 64'(tbl_fac[i]) * (l1 - lr) + 64'(tbl_fac[i+1]) * (lr - l0);
		return 24'(num / (l1 - l0));
	endfunction

	// applies one word to the local table and returns the expected answer
	function automatic out_word_t normalize_word(input in_word_t w);
		out_word_t   o;
		logic [23:0] f;
		logic [63:0] q;
		int          pos;
		o = '0;
		o.status = ST_OK;
		case (w.command)
			CMD_ADD: begin
				if (tbl_cnt >= NPTS) o.status = ST_FULL;
				else begin
					pos = tbl_cnt;
					while (pos > 0 && tbl_val[pos-1] > w.sample_value) begin
						tbl_val[pos] = tbl_val[pos-1];
						tbl_fac[pos] = tbl_fac[pos-1];
						pos--;
					end
					tbl_val[pos] = w.sample_value;
					tbl_fac[pos] = w.point_factor;
					tbl_cnt++;
				end
			end
			CMD_QUERY: begin
				if (tbl_cnt == 0) o.status = ST_EMPTY;
				else begin
					if (w.sample_value < tbl_val[0]) f = tbl_fac[0];
					else if (w.sample_value >= tbl_val[tbl_cnt-1]) f = tbl_fac[tbl_cnt-1];
					else f = interpolated_factor(w.sample_value);
					if (f == 0) o.status = ST_ZERO;
					else begin
						q = (64'(w.sample_value) << 16) / 64'(f);
						o.normalized_value = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
					end
				end
			end
			CMD_CLEAR: tbl_cnt = 0;
			default: ;
		endcase
		return o;
	endfunction

	task automatic send_word(input logic [1:0] c, input logic [31:0] v, input logic [23:0] f);
		in_word_t w;
		int       gap;
		w.command = c;
		w.sample_value = v;
		w.point_factor = f;
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		pending_words = {pending_words, normalize_word(w)};
		words_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: value %h status %0d",
					res.normalized_value, res.status);
			end else begin
				e = pending_words.pop_front();
				status_seen[res.status]++;
				if (res.normalized_value !== e.normalized_value || res.status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %h status %0d, got value %h status %0d",
							e.normalized_value, e.status, res.normalized_value, res.status);
				end
			end
		end
	end

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 65535);
			2: return $urandom >> $urandom_range(0, 31);
			3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom_range(0, 1 << 20);
		endcase
	endfunction

	function automatic logic [23:0] random_factor();
		case ($urandom_range(0, 3))
			0: return 24'($urandom_range(1, 255));
			1: return 24'($urandom);
			default: return 24'($urandom_range(1 << 12, 1 << 20));
		endcase
	endfunction

	task automatic test_empty_table();
		send_word(CMD_QUERY, 32'h0, 24'h0);
		send_word(CMD_QUERY, 32'hFFFF_FFFF, 24'hFF_FFFF);
	endtask

	task automatic test_ordering_and_edges();
		send_word(CMD_ADD, 32'h0000_4000, 24'h02_0000);
		send_word(CMD_ADD, 32'h0000_0100, 24'h01_0000);
		send_word(CMD_ADD, 32'h0000_4000, 24'h04_0000); // tie goes after
		send_word(CMD_ADD, 32'h0010_0000, 24'h00_8000);
		send_word(CMD_QUERY, 32'h0000_0000, 24'h0);      // below first
		send_word(CMD_QUERY, 32'h0000_0100, 24'h0);      // on first point
		send_word(CMD_QUERY, 32'h0000_1000, 24'h0);      // between
		send_word(CMD_QUERY, 32'h0000_4000, 24'h0);      // on tied points
		send_word(CMD_QUERY, 32'h0008_0000, 24'h0);
		send_word(CMD_QUERY, 32'hFFFF_FFFF, 24'h0);      // above last
	endtask

	task automatic test_zero_and_saturation();
		send_word(CMD_CLEAR, 32'h0, 24'h0);
		send_word(CMD_ADD, 32'h0100_0000, 24'h00_0001);
		send_word(CMD_ADD, 32'h0400_0000, 24'h00_0000);
		send_word(CMD_QUERY, 32'hFFFF_FFFF, 24'h0);      // zero divisor
		send_word(CMD_QUERY, 32'h0010_0000, 24'h0);      // overflow saturates
		send_word(CMD_QUERY, 32'h0200_0000, 24'h0);      // interpolated near zero
	endtask

	task automatic test_full_table();
		send_word(CMD_CLEAR, 32'h0, 24'h0);
		for (int k = 0; k < NPTS; k++) send_word(CMD_ADD, random_value(), random_factor());
		send_word(CMD_ADD, 32'h1234_5678, 24'hAB_CDEF);
		send_word(CMD_QUERY, random_value(), 24'h0);
	endtask

	task automatic test_unused_and_clear();
		send_word(CMD_UNUSED, 32'hFFFF_FFFF, 24'hFF_FFFF);
		send_word(CMD_QUERY, 32'h0001_0000, 24'h0);
		send_word(CMD_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF);
		send_word(CMD_QUERY, 32'h0001_0000, 24'h0);
	endtask

	task automatic test_random_tables();
		int          n;
		int          a;
		logic [63:0] lo, hi;
		while (words_sent < 660) begin
			send_word(CMD_CLEAR, $urandom, 24'($urandom));
			n = ($urandom_range(0, 19) == 0) ? NPTS + 1 : $urandom_range(1, 10);
			for (int k = 0; k < n; k++) send_word(CMD_ADD, random_value(), random_factor());
			repeat ($urandom_range(3, 12)) begin
				case ($urandom_range(0, 9))
					0: send_word(CMD_QUERY, random_value(), 24'($urandom));
					1: send_word($urandom_range(0, 1) ? CMD_UNUSED : CMD_ADD,
						random_value(), random_factor());
					default: begin
						// mostly land between neighboring points
						a = $urandom_range(0, tbl_cnt - 1);
						lo = tbl_val[a];
						hi = (a + 1 < tbl_cnt) ? 64'(tbl_val[a+1]) : lo + 64'd4096;
						if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
						send_word(CMD_QUERY, 32'(lo + 64'($urandom) % (hi - lo + 1)),
							24'($urandom));
					end
				endcase
			end
		end
	endtask

	initial begin
		tbl_cnt = 0;
		mismatches = 0;
		words_sent = 0;
		burst_left = 0;
		for (int k = 0; k < 4; k++) status_seen[k] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_ordering_and_edges();
		test_zero_and_saturation();
		test_full_table();
		test_unused_and_clear();
		test_random_tables();
		wait_idle();
		repeat (300) @(posedge clk);
		if (pending_words.size() != 0) mismatches++;
		$display("%0d words sent; answers by status ok/empty/full/zero: %0d/%0d/%0d/%0d",
			words_sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0) begin
			$display("** log_domain_interpolating_normalizer_unit: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** log_domain_interpolating_normalizer_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("** log_domain_interpolating_normalizer_unit: FAILED **");
		$finish;
	end

endmodule
